/* design/tlr_pkg.sv */
// Shared types, character codes and defaults for the text line renderer.
package tlr_pkg;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_CARET  = 8'h5E;

  // Defaults
  localparam int unsigned      TAB_STOP_DEF     = 8;
  localparam logic [7:0]       LINE_WIDTH_RESET = 8'd80;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SECOND
  } state_t;

  // Commands from the sequencer to the column unit
  typedef struct packed {
    logic clear;
    logic inc;
    logic set_full;
  } col_cmd_t;

  // Status from the column unit to the sequencer
  typedef struct packed {
    logic [7:0] column;
    logic [7:0] last_col;
    logic       at_edge;
    logic       next_at_edge;
    logic       tab_wrap;
    logic       full;
  } col_stat_t;

endpackage

/* design/tlr_channels.sv */
// Valid/ready channel interfaces for text bytes in and cell writes out.
interface tlr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic [5:0] row_index;
  logic       line_start;

  modport source (output valid, text_byte, row_index, line_start, input ready);
  modport sink   (input valid, text_byte, row_index, line_start, output ready);
endinterface

interface tlr_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] write_row;
  logic [7:0] write_column;
  logic [7:0] cell_char;
  logic       run_last;

  modport source (output valid, write_row, write_column, cell_char, run_last, input ready);
  modport sink   (input valid, write_row, write_column, cell_char, run_last, output ready);
endinterface

/* design/tlr_col_unit.sv */
// Column unit: column and tab phase registers with the shared incrementer and compares.
module tlr_col_unit #(
  parameter int unsigned TAB_STOP = tlr_pkg::TAB_STOP_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        line_width,
  input  tlr_pkg::col_cmd_t cmd,
  output tlr_pkg::col_stat_t stat
);
  import tlr_pkg::*;

  localparam int unsigned PHASE_W = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TAB_STOP - 1);

  logic [7:0]         column;
  logic [PHASE_W-1:0] phase;
  logic               full;
  logic [8:0]         col_inc;

  // Shared incrementer; 9 bits so column+1 compares cleanly against width 255
  assign col_inc = {1'b0, column} + 9'd1;

  // Column, tab phase and full mark
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      phase  <= '0;
      full   <= 1'b0;
    end else if (cmd.clear) begin
      column <= '0;
      phase  <= '0;
      full   <= 1'b0;
    end else begin
      if (cmd.inc) begin
        column <= col_inc[7:0];
        phase  <= (phase == PHASE_LAST) ? '0 : phase + 1'b1;
      end
      if (cmd.set_full) begin
        full <= 1'b1;
      end
    end
  end

  // Status toward the sequencer
  always_comb begin
    stat.column       = column;
    stat.last_col     = line_width - 8'd1;
    stat.at_edge      = (column >= line_width);
    stat.next_at_edge = (col_inc >= {1'b0, line_width});
    stat.tab_wrap     = (phase == PHASE_LAST);
    stat.full         = full;
  end

endmodule

/* design/tlr_ctrl.sv */
// Sequencer: takes one byte, steps it through its cell writes and holds the output register.
module tlr_ctrl (
  input  logic               clk,
  input  logic               rst,
  tlr_in_if.sink             in_ch,
  tlr_out_if.source          out_ch,
  input  tlr_pkg::col_stat_t stat,
  output tlr_pkg::col_cmd_t  cmd
);
  import tlr_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [7:0] byte_q;
  logic [5:0] row_q;
  logic       accept;
  logic       slot_free;

  // Step decisions
  logic       emit;
  logic       done;
  logic       go_second;
  logic [7:0] emit_col;
  logic [7:0] emit_char;
  logic       emit_last;

  // Output register
  logic       out_valid;
  logic [5:0] out_row;
  logic [7:0] out_col;
  logic [7:0] out_char;
  logic       out_last;

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid || out_ch.ready;

  // Latch the byte on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= in_ch.text_byte;
      row_q  <= in_ch.row_index;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_FIRST;
      end
      ST_FIRST: begin
        if (done) state_next = ST_IDLE;
        else if (go_second) state_next = ST_SECOND;
      end
      ST_SECOND: begin
        if (done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Step outputs: one cell write per cycle at most
  always_comb begin
    emit         = 1'b0;
    done         = 1'b0;
    go_second    = 1'b0;
    emit_col     = stat.column;
    emit_char    = byte_q;
    emit_last    = 1'b0;
    cmd.clear    = accept && in_ch.line_start;
    cmd.inc      = 1'b0;
    cmd.set_full = 1'b0;
    case (state)
      ST_FIRST: begin
        if (stat.full) begin
          // line already full: byte is dropped
          done = 1'b1;
        end else if (slot_free) begin
          emit = 1'b1;
          if (stat.at_edge) begin
            emit_col     = stat.last_col;
            emit_char    = CH_DOLLAR;
            emit_last    = 1'b1;
            cmd.set_full = 1'b1;
            done         = 1'b1;
          end else if (byte_q == CH_TAB) begin
            emit_char = CH_SPACE;
            cmd.inc   = 1'b1;
            emit_last = stat.next_at_edge || stat.tab_wrap;
            done      = emit_last;
          end else if (byte_q < CH_SPACE) begin
            emit_char = CH_CARET;
            cmd.inc   = 1'b1;
            go_second = 1'b1;
          end else begin
            cmd.inc   = 1'b1;
            emit_last = 1'b1;
            done      = 1'b1;
          end
        end
      end
      ST_SECOND: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          done      = 1'b1;
          if (stat.at_edge) begin
            // caret took the last column: overwrite with the full mark
            emit_col     = stat.last_col;
            emit_char    = CH_DOLLAR;
            cmd.set_full = 1'b1;
          end else begin
            emit_char = byte_q + CH_AT;
            cmd.inc   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_row  <= row_q;
      out_col  <= emit_col;
      out_char <= emit_char;
      out_last <= emit_last;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.write_row    = out_row;
  assign out_ch.write_column = out_col;
  assign out_ch.cell_char    = out_char;
  assign out_ch.run_last     = out_last;

endmodule

/* design/text_line_renderer.sv */
// Text line renderer top level: line width register, sequencer and column unit.
//
// Usage:
//   in_ch carries one byte of line text with its screen row and a line_start
//   flag that marks the first byte of a new line. out_ch carries cell writes
//   (row, column, character) with run_last set on the final write of a byte.
//   cfg_we/cfg_wdata write line_width; write it only while the block is idle.
// Sequencing:
//   A byte is taken when in_ch.ready is high, only while the sequencer is
//   idle. Its cell writes follow one per cycle while the output register is
//   free: a printable byte one, a control byte two, a tab up to TAB_STOP, a
//   byte dropped on a full line none. The single column incrementer moves
//   one column per write but the full mark; each write is then registered.
// Stalls:
//   Results sit in a one-entry output register; a stalled receiver holds the
//   sequencer, and the next byte may be taken while the last write waits.
// Reset:
//   rst clears column, full mark and output valid; line_width returns to 80.
module text_line_renderer #(
  parameter int unsigned TAB_STOP = tlr_pkg::TAB_STOP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tlr_in_if.sink     in_ch,
  tlr_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import tlr_pkg::*;

  logic [7:0] line_width;
  col_cmd_t   cmd;
  col_stat_t  stat;

  // Line width register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
    end else if (cfg_we) begin
      line_width <= cfg_wdata;
    end
  end

  tlr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .stat   (stat),
    .cmd    (cmd)
  );

  tlr_col_unit #(
    .TAB_STOP (TAB_STOP)
  ) u_col (
    .clk        (clk),
    .rst        (rst),
    .line_width (line_width),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

/* design/tlr_checker.sv */
// Port-level checks for the text line renderer, bound to the top level.
module tlr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_column,
  input logic [7:0] out_char,
  input logic       out_last
);
  import tlr_pkg::*;

  // Reset leaves the block ready with no write pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

  // A transfer always drops ready while the sequencer handles the byte
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after transfer");

  // A pending write that is not the last one keeps the sequencer busy
  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("new byte taken mid run");

  // The full mark and any plain dollar always end their run
  a_dollar_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_char == CH_DOLLAR) |-> out_last)
    else $error("dollar write not last");

  // Stalled write holds its column
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_column))
    else $error("stalled write changed");

endmodule

bind text_line_renderer tlr_checker u_tlr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_column (out_ch.write_column),
  .out_char   (out_ch.cell_char),
  .out_last   (out_ch.run_last)
);

/* bench/tb_text_line_renderer.sv */
// Testbench for text_line_renderer: directed and random byte streams checked against a predictor.
`timescale 1ns / 100ps

module tb_text_line_renderer;
  import tlr_pkg::*;

  localparam int unsigned TAB_STOP     = TAB_STOP_DEF;
  localparam int unsigned RANDOM_BYTES = 140;
  // A byte dropped on a full line keeps the block busy without any write
  localparam int unsigned TAIL_CYCLES  = 16;

  typedef struct {
    logic [5:0] row;
    logic [7:0] column;
    logic [7:0] cell_char;
    logic       run_last;
  } cell_write_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  tlr_in_if  text_in ();
  tlr_out_if cell_out ();

  text_line_renderer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (text_in),
    .out_ch    (cell_out),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Predictor state and the cell writes still owed by the block
  cell_write_t expected_writes[$];
  logic [7:0]  width_reg;
  logic [7:0]  cursor_col;
  logic        line_is_full;

  int unsigned mismatch_count = 0;
  int unsigned sent_bytes = 0;
  int unsigned burst_left = 0;
  int unsigned max_gap = 3;
  int unsigned hold_request = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void expect_write(logic [5:0] row, logic [7:0] col, logic [7:0] ch);
    cell_write_t w;
    w.row       = row;
    w.column    = col;
    w.cell_char = ch;
    w.run_last  = 1'b0;
    expected_writes.push_back(w);
  endfunction

  // '$' over the last column; the rest of the line is dropped
  function automatic void mark_line_full(logic [5:0] row);
    expect_write(row, width_reg - 8'd1, CH_DOLLAR);
    line_is_full = 1'b1;
  endfunction

  // Returns the number of cell writes this byte causes
  function automatic int render_byte(logic [7:0] text_b, logic [5:0] row, logic start);
    int n;
    n = 0;
    if (start) begin
      cursor_col   = 8'd0;
      line_is_full = 1'b0;
    end
    if (line_is_full) return 0;

    if (cursor_col >= width_reg) begin
      mark_line_full(row);
      n = 1;
    end else if (text_b == CH_TAB) begin
      // spaces up to the next tab stop, clipped at the line width
      do begin
        expect_write(row, cursor_col, CH_SPACE);
        n++;
        cursor_col++;
      end while (cursor_col < width_reg && (cursor_col % TAB_STOP) != 0);
    end else if (text_b < CH_SPACE) begin
      // caret notation: '^' then byte + '@'
      expect_write(row, cursor_col, CH_CARET);
      n++;
      cursor_col++;
      if (cursor_col >= width_reg) begin
        mark_line_full(row);
        n++;
      end else begin
        expect_write(row, cursor_col, text_b + CH_AT);
        n++;
        cursor_col++;
      end
    end else begin
      expect_write(row, cursor_col, text_b);
      n++;
      cursor_col++;
    end

    expected_writes[expected_writes.size() - 1].run_last = 1'b1;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // One transfer on the text channel, with bursts and random gaps between them
  task automatic send_byte(logic [7:0] text_b, logic [5:0] row, logic start);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
        text_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    text_in.valid      <= 1'b1;
    text_in.text_byte  <= text_b;
    text_in.row_index  <= row;
    text_in.line_start <= start;
    do @(posedge clk); while (!text_in.ready);
    void'(render_byte(text_b, row, start));
    sent_bytes++;
  endtask

  // Stop offering, wait for every owed write, then let the block settle
  task automatic drain_writes();
    text_in.valid <= 1'b0;
    burst_left = 0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_width(logic [7:0] w);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_reg = w;
  endtask

  function automatic logic [7:0] pick_text_byte(int unsigned tab_weight);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < tab_weight) return CH_TAB;
    if (p < tab_weight + 20) return 8'($urandom_range(0, 31));
    if (p < tab_weight + 25) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32, 255));
  endfunction

  // A line on one row, with a few stray rows and stray line starts as noise
  task automatic send_random_line(int unsigned len, int unsigned tab_weight, logic fresh);
    logic [5:0] row;
    logic [5:0] r;
    logic       s;
    row = 6'($urandom_range(0, 63));
    for (int i = 0; i < len; i++) begin
      r = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : row;
      s = (i == 0) ? fresh : ($urandom_range(0, 29) == 0);
      send_byte(pick_text_byte(tab_weight), r, s);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: ready pattern steps through four modes; a hold-off request wins
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned hold_left;
    int unsigned pace_cycle;
    hold_left  = 0;
    pace_cycle = 0;
    cell_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      pace_cycle++;
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        cell_out.ready <= 1'b0;
      end else begin
        case ((pace_cycle / 400) % 4)
          0:       cell_out.ready <= 1'b1;
          1:       cell_out.ready <= ($urandom_range(0, 1) == 1);
          2:       cell_out.ready <= (pace_cycle % 4 == 0);
          default: cell_out.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every cell write transfer against the oldest owed write
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cell_write_t w;
    if (!rst && cell_out.valid && cell_out.ready) begin
      if (expected_writes.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected write row=%0d col=%0d ch=%02h last=%0b", $realtime,
                   cell_out.write_row, cell_out.write_column, cell_out.cell_char,
                   cell_out.run_last);
        mismatch_count++;
      end else begin
        w = expected_writes.pop_front();
        if (cell_out.write_row !== w.row || cell_out.write_column !== w.column ||
            cell_out.cell_char !== w.cell_char || cell_out.run_last !== w.run_last) begin
          if (mismatch_count < 10)
            $display("%0t: mismatch exp r=%0d c=%0d ch=%02h l=%0b got r=%0d c=%0d ch=%02h l=%0b",
                     $realtime, w.row, w.column, w.cell_char, w.run_last,
                     cell_out.write_row, cell_out.write_column, cell_out.cell_char,
                     cell_out.run_last);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Width from reset: plain bytes, byte extremes, control bytes and a full tab
  task automatic test_default_width();
    send_byte("A", 6'd0, 1'b1);
    send_byte(8'h00, 6'd63, 1'b0);
    send_byte(8'h1F, 6'd17, 1'b0);
    send_byte(8'h20, 6'd17, 1'b0);
    send_byte(8'hFF, 6'd42, 1'b0);
    send_byte(8'h7F, 6'd42, 1'b0);
    send_byte(CH_TAB, 6'd21, 1'b0);
    drain_writes();
  endtask

  // Width of one tab stop: control byte landing on the last column, full line, tab to edge
  task automatic test_narrow_line_edges();
    set_line_width(8'd8);
    send_byte(8'h05, 6'd5, 1'b1);
    send_byte(8'h06, 6'd5, 1'b0);
    send_byte(CH_TAB - 8'h02, 6'd5, 1'b0);
    send_byte("z", 6'd5, 1'b0);
    send_byte(8'h1B, 6'd5, 1'b0);   // '^' on last column, then '$' over it
    send_byte("q", 6'd5, 1'b0);     // dropped: line full
    send_byte(CH_TAB, 6'd9, 1'b1);  // eight spaces
    send_byte("x", 6'd9, 1'b0);     // '$' at column 7
    drain_writes();
  endtask

  // Width not on a tab stop: the tab is clipped, next byte hits the edge
  task automatic test_tab_clip();
    set_line_width(8'd10);
    send_byte("a", 6'd2, 1'b1);
    send_byte(CH_TAB, 6'd2, 1'b0);
    send_byte(CH_TAB, 6'd2, 1'b0);
    send_byte("b", 6'd2, 1'b0);
    drain_writes();
  endtask

  // Width lowered under the current column in the middle of a line
  task automatic test_width_lowered_mid_line();
    set_line_width(8'd20);
    send_byte(CH_TAB, 6'd3, 1'b1);
    send_byte(CH_TAB, 6'd3, 1'b0);
    send_byte("c", 6'd3, 1'b0);
    drain_writes();
    set_line_width(8'd9);
    send_byte("d", 6'd3, 1'b0);
    drain_writes();
  endtask

  // Width zero: last column wraps to 255, first byte marks the line full
  task automatic test_zero_width();
    set_line_width(8'd0);
    send_byte("k", 6'd4, 1'b1);
    send_byte("m", 6'd4, 1'b0);
    drain_writes();
  endtask

  // Receiver holds off for a long stretch while bytes keep coming back to back
  task automatic test_output_backpressure();
    set_line_width(LINE_WIDTH_RESET);
    max_gap = 0;
    hold_request = 150;
    send_random_line(24, 30, 1'b1);
    drain_writes();
    max_gap = 3;
  endtask

  // Random lines over a spread of widths, some continuing across a width change
  task automatic test_random_lines();
    int unsigned first_count;
    int unsigned phase;
    int unsigned w;
    int unsigned len;
    int unsigned tab_w;
    first_count = sent_bytes;
    phase = 0;
    while (sent_bytes - first_count < RANDOM_BYTES) begin
      case (phase % 6)
        0:       w = 255;
        1:       w = 8;
        2:       w = $urandom_range(9, 40);
        3:       w = 80;
        4:       w = $urandom_range(8, 255);
        default: w = $urandom_range(8, 16);
      endcase
      set_line_width(8'(w));
      max_gap = (phase % 3 == 0) ? 0 : 6;
      for (int l = 0; l < 3; l++) begin
        if (w >= 200) begin
          len   = (l == 0) ? 44 : $urandom_range(2, 20);
          tab_w = (l == 0) ? 90 : 30;
        end else begin
          len   = $urandom_range(2, w / 5 + 8);
          tab_w = $urandom_range(5, 40);
        end
        send_random_line(len, tab_w, (l != 0) || ($urandom_range(0, 1) == 1));
      end
      drain_writes();
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    text_in.valid      = 1'b0;
    text_in.text_byte  = 8'd0;
    text_in.row_index  = 6'd0;
    text_in.line_start = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = 8'd0;
    width_reg          = LINE_WIDTH_RESET;
    cursor_col         = 8'd0;
    line_is_full       = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_default_width();
    test_narrow_line_edges();
    test_tab_clip();
    test_width_lowered_mid_line();
    test_zero_width();
    test_output_backpressure();
    test_random_lines();

    drain_writes();
    mismatch_count += expected_writes.size();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(4_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
